@@ hw/rtl/srcr_pkg.sv @@
// ----------------------------------------------------------------------------
// srcr_pkg
// Shared types and constants for the shift register chain reader.
// ----------------------------------------------------------------------------
`default_nettype none

package srcr_pkg;

  localparam int MAX_CHIPS  = 16;
  localparam int CHIP_W     = $clog2(MAX_CHIPS);
  localparam int DEPTH_W    = 5;
  localparam int NUM_WORDS  = MAX_CHIPS / 2;
  localparam int WIDX_W     = 3;
  localparam int BYTE_W     = 8;
  localparam int WORD_W     = 2 * BYTE_W;
  localparam int BIT_CNT_W  = $clog2(BYTE_W);

  localparam logic [DEPTH_W-1:0]   DEPTH_RESET = DEPTH_W'(2);
  localparam logic [DEPTH_W-1:0]   DEPTH_MAX   = DEPTH_W'(MAX_CHIPS);
  localparam logic [BIT_CNT_W-1:0] LAST_BIT    = BIT_CNT_W'(BYTE_W - 1);

  typedef enum logic {
    FUNC_TICK = 1'b0,
    FUNC_READ = 1'b1
  } func_t;

  typedef struct packed {
    logic              en;
    logic [CHIP_W-1:0] addr;
    logic [BYTE_W-1:0] data;
  } store_wr_t;

endpackage

`default_nettype wire

@@ hw/rtl/srcr_ctrl.sv @@
// ----------------------------------------------------------------------------
// srcr_ctrl
// Bit and chip counters, byte assembly, latch line and chain depth register.
// ----------------------------------------------------------------------------
`default_nettype none

module srcr_ctrl
  import srcr_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               accept,
  input  wire func_t              func,
  input  wire logic               clk_level,
  input  wire logic               data_pin,
  input  wire logic               cfg_wr_en,
  input  wire logic [DEPTH_W-1:0] cfg_wr_data,
  output store_wr_t               wr,
  output logic                    latch_next,
  output logic                    done_next
);

  logic [DEPTH_W-1:0]   chain_depth;
  logic [BIT_CNT_W-1:0] bit_count;
  logic [BIT_CNT_W-1:0] bit_count_next;
  logic [CHIP_W-1:0]    chip_count;
  logic [CHIP_W-1:0]    chip_count_next;
  logic [BYTE_W-1:0]    assembling_byte;
  logic [BYTE_W-1:0]    assembling_byte_next;
  logic                 latch_state;
  logic [DEPTH_W-1:0]   depth_sat;
  logic [DEPTH_W-1:0]   chip_inc;
  logic [BIT_CNT_W-1:0] bit_pos;

  always_comb begin
    depth_sat            = (chain_depth > DEPTH_MAX) ? DEPTH_MAX : chain_depth;
    chip_inc             = DEPTH_W'(chip_count) + DEPTH_W'(1);
    bit_pos              = LAST_BIT - bit_count;
    bit_count_next       = bit_count;
    chip_count_next      = chip_count;
    assembling_byte_next = assembling_byte;
    latch_next           = latch_state;
    done_next            = 1'b0;
    wr.en                = 1'b0;
    wr.addr              = chip_count;
    wr.data              = assembling_byte;
    case (func)
      FUNC_READ: begin
      end
      FUNC_TICK: begin
        if (clk_level) begin
          if (bit_count == LAST_BIT) begin
            bit_count_next       = '0;
            wr.en                = 1'b1;
            assembling_byte_next = '0;
            if (chip_inc >= depth_sat) begin
              chip_count_next = '0;
              latch_next      = 1'b0;
              done_next       = 1'b1;
            end else begin
              chip_count_next = chip_inc[CHIP_W-1:0];
            end
          end else begin
            bit_count_next = bit_count + BIT_CNT_W'(1);
          end
        end else begin
          if (chip_count == '0 && bit_count == '0) begin
            latch_next = 1'b1;
          end
          assembling_byte_next = assembling_byte | (BYTE_W'(data_pin) << bit_pos);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chain_depth     <= DEPTH_RESET;
      bit_count       <= '0;
      chip_count      <= '0;
      assembling_byte <= '0;
      latch_state     <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        chain_depth <= cfg_wr_data;
      end
      if (accept) begin
        bit_count       <= bit_count_next;
        chip_count      <= chip_count_next;
        assembling_byte <= assembling_byte_next;
        latch_state     <= latch_next;
      end
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/srcr_store.sv @@
// ----------------------------------------------------------------------------
// srcr_store
// Byte store held as 16-bit rows with per-byte valid bits and a registered
// word read port.
// ----------------------------------------------------------------------------
`default_nettype none

module srcr_store
  import srcr_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire store_wr_t         wr,
  input  wire logic              rd_en,
  input  wire logic [WIDX_W-1:0] rd_index,
  output logic [WORD_W-1:0]      rd_word
);

  logic [WORD_W-1:0]    mem [NUM_WORDS];
  logic [MAX_CHIPS-1:0] byte_valid;
  logic [WORD_W-1:0]    rd_data;
  logic                 rd_hi_valid;
  logic                 rd_lo_valid;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      if (wr.addr[0]) begin
        mem[wr.addr[CHIP_W-1:1]][BYTE_W-1:0] <= wr.data;
      end else begin
        mem[wr.addr[CHIP_W-1:1]][WORD_W-1:BYTE_W] <= wr.data;
      end
    end
    if (rd_en) begin
      rd_data     <= mem[rd_index];
      rd_hi_valid <= byte_valid[{rd_index, 1'b0}];
      rd_lo_valid <= byte_valid[{rd_index, 1'b1}];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= '0;
    end else if (wr.en) begin
      byte_valid[wr.addr] <= 1'b1;
    end
  end

  assign rd_word = {rd_data[WORD_W-1:BYTE_W] & {BYTE_W{rd_hi_valid}},
                    rd_data[BYTE_W-1:0] & {BYTE_W{rd_lo_valid}}};

endmodule

`default_nettype wire

@@ hw/rtl/shift_register_chain_reader_unit.sv @@
// ----------------------------------------------------------------------------
// shift_register_chain_reader_unit
// Reads a daisy chain of 8-bit parallel-in serial-out shift registers.
//
// Each input transaction is either a clock tick that carries the shift clock
// level and the sampled serial data pin, or a read of one stored 16-bit word.
// Every input transaction produces exactly one output transaction carrying
// the latch line level, the end-of-frame flag and, for reads, the word.
// The user must write the chain depth register through cfg_wr_en and
// cfg_wr_data only while no transaction is in flight; the block itself
// does not enforce it. out_valid rises in the cycle after acceptance. The
// block accepts one transaction per cycle; the single output register is
// the only buffer, so in_ready drops only while a result waits and
// out_ready is low. The byte store is read through one registered port
// indexed by word. Reset clears the counters, the latch line, the output
// valid flag and the byte valid bits, so every byte reads as zero until it
// is filled; the chain depth returns to two.
// ----------------------------------------------------------------------------
`default_nettype none

module shift_register_chain_reader_unit
  import srcr_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_wr_en,
  input  wire logic [DEPTH_W-1:0] cfg_wr_data,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               func,
  input  wire logic               clk_level,
  input  wire logic               data_pin,
  input  wire logic [WIDX_W-1:0]  word_index,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    latch_level,
  output logic                    frame_done,
  output logic                    read_valid,
  output logic [WORD_W-1:0]       read_word
);

  store_wr_t         wr;
  logic              accept;
  logic              latch_next;
  logic              done_next;
  logic              is_read;
  logic [WORD_W-1:0] rd_word;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign is_read  = (func_t'(func) == FUNC_READ);

  srcr_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .func        (func_t'(func)),
    .clk_level   (clk_level),
    .data_pin    (data_pin),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .wr          (wr),
    .latch_next  (latch_next),
    .done_next   (done_next)
  );

  srcr_store u_store (
    .clk      (clk),
    .rst      (rst),
    .wr       (store_wr_t'({wr.en && accept, wr.addr, wr.data})),
    .rd_en    (accept && is_read),
    .rd_index (word_index),
    .rd_word  (rd_word)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      latch_level <= latch_next;
      frame_done  <= done_next;
      read_valid  <= is_read;
    end
  end

  assign read_word = read_valid ? rd_word : '0;

  a_done_drops_latch : assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_done |-> !latch_level)
    else $error("frame_done with latch line high");

  a_done_not_read : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(frame_done && read_valid))
    else $error("frame_done on a read transaction");

  a_read_follows : assert property (@(posedge clk) disable iff (rst)
    accept && is_read |=> out_valid && read_valid)
    else $error("read transaction did not produce a read result");

  a_tick_word_zero : assert property (@(posedge clk) disable iff (rst)
    out_valid && !read_valid |-> read_word == '0)
    else $error("tick result carries a nonzero word");

endmodule

`default_nettype wire
